@@ hw/rtl/crc_pkg.sv @@
// Shared constants and types for the circle outline rasterizer.
`default_nettype none
package crc_pkg;

	localparam int COORD_BITS = 8;
	localparam int STEP_BITS  = COORD_BITS + 1;
	localparam int DEC_BITS   = COORD_BITS + 4;
	localparam int COLOR_BITS = 24;
	localparam int PIX_PER_STEP = 8;
	localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// one step worth of work for the emit side
	typedef struct packed {
		logic [COORD_BITS-1:0] cen_col;
		logic [COORD_BITS-1:0] cen_row;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] color;
		logic                  done;
	} step_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/crc_front.sv @@
// Front end: takes start/step items, runs the Andres iterator, queues step records.
`default_nettype none
module crc_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               action,
	input  wire logic [crc_pkg::COORD_BITS-1:0]     center_col,
	input  wire logic [crc_pkg::COORD_BITS-1:0]     center_row,
	input  wire logic [crc_pkg::COORD_BITS-1:0]     radius,
	input  wire logic [crc_pkg::COLOR_BITS-1:0]     color,
	input  wire crc_pkg::fifo_stat_t                fifo_stat,
	output logic                                    push,
	output crc_pkg::step_rec_t                      push_rec
);

	localparam int SW = crc_pkg::STEP_BITS;
	localparam int DW = crc_pkg::DEC_BITS;
	localparam int CW = crc_pkg::COORD_BITS;

	logic                  active_q;
	logic [CW-1:0]         cen_col_q;
	logic [CW-1:0]         cen_row_q;
	logic [CW-1:0]         radius_q;
	logic [crc_pkg::COLOR_BITS-1:0] color_q;
	logic signed [SW-1:0]  step_x_q;
	logic signed [SW-1:0]  step_y_q;
	logic signed [DW-1:0]  dec_q;

	logic                  accept;
	logic                  live;
	logic signed [DW-1:0]  xe, ye, re;
	logic signed [DW-1:0]  dec_nx;
	logic signed [SW-1:0]  x_nx, y_nx;
	logic                  done_nx;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign live     = active_q && (step_y_q >= step_x_q);

	always_comb begin
		xe = DW'(step_x_q);
		ye = DW'(step_y_q);
		re = $signed({{(DW-CW){1'b0}}, radius_q});
		if (dec_q >= (xe <<< 1)) begin
			dec_nx = dec_q - ((xe <<< 1) + DW'(1));
			x_nx   = step_x_q + SW'(1);
			y_nx   = step_y_q;
		end else if (dec_q < ((re - ye) <<< 1)) begin
			dec_nx = dec_q + ((ye <<< 1) - DW'(1));
			x_nx   = step_x_q;
			y_nx   = step_y_q - SW'(1);
		end else begin
			dec_nx = dec_q + ((ye - xe - DW'(1)) <<< 1);
			x_nx   = step_x_q + SW'(1);
			y_nx   = step_y_q - SW'(1);
		end
		done_nx = (y_nx < x_nx);
	end

	assign push = accept && (action == crc_pkg::ACT_STEP) && live;

	always_comb begin
		push_rec.cen_col = cen_col_q;
		push_rec.cen_row = cen_row_q;
		push_rec.x       = step_x_q[CW-1:0];
		push_rec.y       = step_y_q[CW-1:0];
		push_rec.color   = color_q;
		push_rec.done    = done_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			cen_col_q <= '0;
			cen_row_q <= '0;
			radius_q  <= '0;
			color_q   <= '0;
			step_x_q  <= '0;
			step_y_q  <= '0;
			dec_q     <= '0;
		end else if (accept) begin
			if (action == crc_pkg::ACT_START) begin
				active_q  <= 1'b1;
				cen_col_q <= center_col;
				cen_row_q <= center_row;
				radius_q  <= radius;
				color_q   <= color;
				step_x_q  <= '0;
				step_y_q  <= $signed({1'b0, radius});
				dec_q     <= $signed({{(DW-CW){1'b0}}, radius}) - DW'(1);
			end else if (!live) begin
				active_q <= 1'b0;
			end else begin
				step_x_q <= x_nx;
				step_y_q <= y_nx;
				dec_q    <= dec_nx;
				if (done_nx)
					active_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/crc_fifo.sv @@
// Short queue of step records between the front end and the pixel emitter.
`default_nettype none
module crc_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire crc_pkg::step_rec_t  push_rec,
	input  wire logic                pop,
	output crc_pkg::step_rec_t       head_rec,
	output crc_pkg::fifo_stat_t      stat
);

	localparam int PW = crc_pkg::FIFO_PTR_BITS;
	localparam int NW = crc_pkg::FIFO_CNT_BITS;

	crc_pkg::step_rec_t   mem_q [crc_pkg::FIFO_DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [NW-1:0]        count_q;

	assign head_rec   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == NW'(crc_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(crc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(crc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/crc_back.sv @@
// Back end: expands each step record into its eight symmetric pixels.
`default_nettype none
module crc_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire crc_pkg::step_rec_t              head_rec,
	input  wire crc_pkg::fifo_stat_t             fifo_stat,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [crc_pkg::COORD_BITS-1:0]       pixel_col,
	output logic [crc_pkg::COORD_BITS-1:0]       pixel_row,
	output logic [crc_pkg::COLOR_BITS-1:0]       pixel_color,
	output logic                                 last_of_step,
	output logic                                 circle_done
);

	localparam int CW = crc_pkg::COORD_BITS;
	localparam int KW = crc_pkg::PIX_IDX_BITS;

	logic [KW-1:0]  pix_q;
	logic           out_valid_q;
	logic [CW-1:0]  col_q, row_q;
	logic [crc_pkg::COLOR_BITS-1:0] color_q;
	logic           last_q, done_q;

	logic           load;
	logic           last_pix;
	logic [CW-1:0]  du, dv, col_nx, row_nx;

	assign load     = !fifo_stat.empty && (!out_valid_q || out_ready);
	assign last_pix = (pix_q == KW'(crc_pkg::PIX_PER_STEP - 1));
	assign pop      = load && last_pix;

	// bit 0 swaps x/y, bit 1 mirrors the column, bit 2 mirrors the row
	always_comb begin
		du     = pix_q[0] ? head_rec.y : head_rec.x;
		dv     = pix_q[0] ? head_rec.x : head_rec.y;
		col_nx = pix_q[1] ? head_rec.cen_col - du : head_rec.cen_col + du;
		row_nx = pix_q[2] ? head_rec.cen_row - dv : head_rec.cen_row + dv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pix_q       <= last_pix ? '0 : pix_q + KW'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q   <= col_nx;
			row_q   <= row_nx;
			color_q <= head_rec.color;
			last_q  <= last_pix;
			done_q  <= last_pix && head_rec.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_col    = col_q;
	assign pixel_row    = row_q;
	assign pixel_color  = color_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule
`default_nettype wire

@@ hw/rtl/circle_outline_rasterizer.sv @@
// Top level of the circle outline rasterizer: front end, step queue and pixel emitter.
// The first pixel of a step is registered in the step queue, then in the output register.
// One pixel per cycle leaves the output register while out_ready is high and a step
// is queued, eight pixels per step; start items and idle steps give no pixels.
// The front end takes a new item each cycle while the two-entry step queue has room.
// Reset (arst_n low): idle, queue empty, output invalid, iterator state cleared.
`default_nettype none
module circle_outline_rasterizer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             action,
	input  wire logic [crc_pkg::COORD_BITS-1:0]   center_col,
	input  wire logic [crc_pkg::COORD_BITS-1:0]   center_row,
	input  wire logic [crc_pkg::COORD_BITS-1:0]   radius,
	input  wire logic [crc_pkg::COLOR_BITS-1:0]   color,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [crc_pkg::COORD_BITS-1:0]        pixel_col,
	output logic [crc_pkg::COORD_BITS-1:0]        pixel_row,
	output logic [crc_pkg::COLOR_BITS-1:0]        pixel_color,
	output logic                                  last_of_step,
	output logic                                  circle_done
);

	crc_pkg::fifo_stat_t fifo_stat;
	crc_pkg::step_rec_t  push_rec;
	crc_pkg::step_rec_t  head_rec;
	logic                push;
	logic                pop;

	crc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.center_col (center_col),
		.center_row (center_row),
		.radius     (radius),
		.color      (color),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_rec   (push_rec)
	);

	crc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.stat     (fifo_stat)
	);

	crc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_rec     (head_rec),
		.fifo_stat    (fifo_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.pixel_color  (pixel_color),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule
`default_nettype wire
